@@ rtl/core/pulse_frequency_band_classifier_macros.svh @@
// assertion macros used by the pulse frequency band classifier top level
`ifndef PULSE_FREQUENCY_BAND_CLASSIFIER_MACROS_SVH
`define PULSE_FREQUENCY_BAND_CLASSIFIER_MACROS_SVH

// condition implies consequence in the same cycle
`define PFBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define PFBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/pfbc_pkg.sv @@
// shared types and constants of the pulse frequency band classifier
package pfbc_pkg;

    // default ring depth
    localparam int PFBC_DEPTH = 9;

    // configuration register indexes
    localparam logic [2:0] REG_MAX_SPAN    = 3'd0;
    localparam logic [2:0] REG_MAX_AGE     = 3'd1;
    localparam logic [2:0] REG_ENEMY_LOW   = 3'd2;
    localparam logic [2:0] REG_ENEMY_HIGH  = 3'd3;
    localparam logic [2:0] REG_FRIEND_LOW  = 3'd4;
    localparam logic [2:0] REG_FRIEND_HIGH = 3'd5;

    // configuration reset values
    localparam logic [31:0] RST_MAX_SPAN    = 32'd200000;
    localparam logic [31:0] RST_MAX_AGE     = 32'd1000000;
    localparam logic [19:0] RST_ENEMY_LOW   = 20'd830;
    localparam logic [19:0] RST_ENEMY_HIGH  = 20'd870;
    localparam logic [19:0] RST_FRIEND_LOW  = 20'd3900;
    localparam logic [19:0] RST_FRIEND_HIGH = 20'd4100;

    // beacon class codes
    localparam logic [1:0] CLS_NONE   = 2'd0;
    localparam logic [1:0] CLS_FRIEND = 2'd1;
    localparam logic [1:0] CLS_ENEMY  = 2'd2;
    localparam logic [1:0] CLS_BOTH   = 2'd3;

    // divider iteration count and aligned frequency numerator
    localparam logic [5:0]  DIV_FREQ_ITERS   = 6'd20;
    localparam logic [31:0] FREQ_NUMERATOR   = 32'd1000000;
    localparam logic [31:0] FREQ_NUM_ALIGNED = FREQ_NUMERATOR << (32 - 20);

    // period limits
    localparam logic [31:0] PERIOD_LIMIT = 32'd100000;
    localparam logic [31:0] BOTH_PERIOD  = 32'd3;

    // divider request
    typedef struct packed {
        logic       start;
        logic [5:0] iters;
    } t_div_req;

endpackage

@@ rtl/core/pfbc_ring.sv @@
// ring memory of edge timestamps with per-entry valid bits
module pfbc_ring
    import pfbc_pkg::*;
#(
    parameter int DEPTH = PFBC_DEPTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr_old,
    input  logic [AW-1:0] i_raddr_new,
    output logic [31:0]   o_rdata_old,
    output logic [31:0]   o_rdata_new
);

    logic [31:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [31:0]      r_rd_old;
    logic [31:0]      r_rd_new;
    logic             r_hit_old;
    logic             r_hit_new;

    // timestamp storage
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_old <= r_mem[i_raddr_old];
            r_rd_new <= r_mem[i_raddr_new];
        end
    end

    // written flags, cleared at reset so unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_hit_old <= 1'b0;
            r_hit_new <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_hit_old <= r_valid[i_raddr_old];
                r_hit_new <= r_valid[i_raddr_new];
            end
        end
    end

    assign o_rdata_old = r_hit_old ? r_rd_old : '0;
    assign o_rdata_new = r_hit_new ? r_rd_new : '0;

endmodule

@@ rtl/core/pfbc_div.sv @@
// iterative restoring divider, one quotient bit per cycle
module pfbc_div
    import pfbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_dvs;
    logic [31:0] r_quo;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        q_bit;

    // one trial subtraction
    always_comb begin
        trial = {r_rem, r_num[31]};
        diff  = trial - {1'b0, r_dvs};
        q_bit = !diff[32];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= q_bit ? diff[31:0] : trial[31:0];
            r_quo <= {r_quo[30:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ rtl/core/pulse_frequency_band_classifier.sv @@
// pulse frequency band classifier top level
//
// input channel: i_in_valid / o_in_stall carrying i_command and i_time_us.
// a transfer with command 0 stores the edge time in the ring; no result
// follows. a transfer with command 1 is a query: it reads the oldest and
// newest stored edges, rewinds the write slot, checks span and age against
// the limits, scales the span by a reciprocal of DEPTH-1 to get the period
// and then divides 1000000 by the period.
// a query result leaves on o_out_valid / i_out_stall with o_period_us,
// o_freq_hz and o_beacon_class after the memory read and limit check, the
// period correction, the one-bit-per-cycle frequency division and the steps
// that classify and register the result. a rejected query skips straight to
// a zero result, a period out of range skips the division. stall is raised
// from the query transfer until its result is registered, so no new item is
// taken while a query runs; edges stream at one per cycle when no query is
// in progress. the result sits in an output register, so the next item is
// taken while it waits; a further query result waits until that register
// is free.
// reset restores the register defaults, rewinds the write slot and marks
// every ring entry unwritten so it reads as zero; no clearing pass is needed.
`include "pulse_frequency_band_classifier_macros.svh"

module pulse_frequency_band_classifier
    import pfbc_pkg::*;
#(
    parameter int DEPTH = PFBC_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [31:0] i_time_us,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_period_us,
    output logic [19:0] o_freq_hz,
    output logic [1:0]  o_beacon_class,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int          AW           = $clog2(DEPTH);
    localparam logic [31:0] SPAN_DIVISOR = 32'(DEPTH - 1);
    localparam logic [31:0] SPAN_RECIP   = 32'((64'd1 << 32) / 64'(DEPTH - 1));

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_RANGE = 7'b0001000,
        S_DIV2  = 7'b0010000,
        S_CLASS = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_slot;
    logic [31:0]   r_now;
    logic [63:0]   r_scaled;
    logic [31:0]   r_period;
    logic [19:0]   r_freq;
    logic [1:0]    r_cls;
    logic          r_out_valid;
    logic [31:0]   r_out_period;
    logic [19:0]   r_out_freq;
    logic [1:0]    r_out_cls;

    logic [31:0] r_max_span;
    logic [31:0] r_max_age;
    logic [19:0] r_enemy_low;
    logic [19:0] r_enemy_high;
    logic [19:0] r_friend_low;
    logic [19:0] r_friend_high;

    logic          in_xfer;
    logic          edge_wr;
    logic          query_rd;
    logic [AW-1:0] newest_addr;
    logic [31:0]   oldest;
    logic [31:0]   newest;
    logic [31:0]   span;
    logic [31:0]   age;
    logic          reject;
    logic          in_range;
    logic          out_free;
    logic [31:0]   q_est;
    logic [31:0]   q_times_d;
    logic [31:0]   q_rem;
    logic [31:0]   period_fix;
    t_div_req      div_req;
    logic [31:0]   div_dividend;
    logic [31:0]   div_divisor;
    logic          div_done;
    logic [31:0]   div_quo;

    // input transfers
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign edge_wr     = in_xfer && !i_command;
    assign query_rd    = in_xfer && i_command;
    assign o_in_stall  = (r_state != S_IDLE);
    assign newest_addr = (r_slot == '0) ? AW'(DEPTH - 1) : r_slot - AW'(1);

    // ring of edge timestamps
    pfbc_ring #(
        .DEPTH(DEPTH)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (edge_wr),
        .i_waddr    (r_slot),
        .i_wdata    (i_time_us),
        .i_re       (query_rd),
        .i_raddr_old(r_slot),
        .i_raddr_new(newest_addr),
        .o_rdata_old(oldest),
        .o_rdata_new(newest)
    );

    // span and age checks
    assign span     = newest - oldest;
    assign age      = r_now - oldest;
    assign reject   = (span > r_max_span) || (age > r_max_age);
    assign in_range = (r_period != '0) && (r_period < PERIOD_LIMIT);
    assign out_free = !r_out_valid || !i_out_stall;

    // period: reciprocal estimate is at most one low, one compare corrects it
    assign q_est      = r_scaled[63:32];
    assign q_times_d  = q_est * SPAN_DIVISOR;
    assign q_rem      = span - q_times_d;
    assign period_fix = (q_rem >= SPAN_DIVISOR) ? q_est + 32'd1 : q_est;

    // divider request for the frequency
    always_comb begin
        div_req.start = (r_state == S_RANGE) && in_range;
        div_req.iters = DIV_FREQ_ITERS;
        div_dividend  = FREQ_NUM_ALIGNED;
        div_divisor   = r_period;
    end

    pfbc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_span    <= RST_MAX_SPAN;
            r_max_age     <= RST_MAX_AGE;
            r_enemy_low   <= RST_ENEMY_LOW;
            r_enemy_high  <= RST_ENEMY_HIGH;
            r_friend_low  <= RST_FRIEND_LOW;
            r_friend_high <= RST_FRIEND_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAX_SPAN:    r_max_span    <= i_cfg_data;
                REG_MAX_AGE:     r_max_age     <= i_cfg_data;
                REG_ENEMY_LOW:   r_enemy_low   <= i_cfg_data[19:0];
                REG_ENEMY_HIGH:  r_enemy_high  <= i_cfg_data[19:0];
                REG_FRIEND_LOW:  r_friend_low  <= i_cfg_data[19:0];
                REG_FRIEND_HIGH: r_friend_high <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and write slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (edge_wr) begin
                        r_slot <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + AW'(1);
                    end else if (query_rd) begin
                        r_slot  <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: r_state <= reject ? S_DONE : S_SCALE;
                S_SCALE: r_state <= S_RANGE;
                S_RANGE: r_state <= in_range ? S_DIV2 : S_CLASS;
                S_DIV2: begin
                    if (div_done) begin
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // measurement datapath
    always_ff @(posedge i_clk) begin
        if (query_rd) begin
            r_now <= i_time_us;
        end
        case (r_state)
            S_CHECK: begin
                if (reject) begin
                    r_period <= '0;
                    r_freq   <= '0;
                    r_cls    <= CLS_NONE;
                end else begin
                    r_scaled <= 64'(span) * 64'(SPAN_RECIP);
                end
            end
            S_SCALE: begin
                r_period <= period_fix;
            end
            S_RANGE: begin
                if (!in_range) begin
                    r_freq <= '0;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    r_freq <= div_quo[19:0];
                end
            end
            S_CLASS: begin
                if (r_period == BOTH_PERIOD) begin
                    r_cls <= CLS_BOTH;
                end else if ((r_enemy_low < r_freq) && (r_freq < r_enemy_high)) begin
                    r_cls <= CLS_ENEMY;
                end else if ((r_friend_low < r_freq) && (r_freq < r_friend_high)) begin
                    r_cls <= CLS_FRIEND;
                end else begin
                    r_cls <= CLS_NONE;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == S_DONE) && out_free) || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_period <= r_period;
            r_out_freq   <= r_freq;
            r_out_cls    <= r_cls;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_period_us    = r_out_period;
    assign o_freq_hz      = r_out_freq;
    assign o_beacon_class = r_out_cls;

    // checks
    `PFBC_ASSERT_NEXT(a_query_rewinds, query_rd, r_slot == '0, "query did not rewind slot")
    `PFBC_ASSERT_NOW(a_freq_div_range, (r_state == S_DIV2) && div_done, (r_period != '0) && (r_period < PERIOD_LIMIT), "frequency division on period out of range")
    `PFBC_ASSERT_NOW(a_both_period, o_out_valid && (o_beacon_class == CLS_BOTH), o_period_us == BOTH_PERIOD, "class both without period three")
    `PFBC_ASSERT_NOW(a_freq_needs_period, o_out_valid && (o_freq_hz != '0), (o_period_us != '0) && (o_period_us < PERIOD_LIMIT), "frequency without valid period")

endmodule
